[design/sblc_pkg.sv]
// Shared types and constants for the size-bounded LRU cache.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sblc_pkg;

  localparam int unsigned SBLC_ENTRIES = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 3;

  localparam logic [TOTAL_W-1:0] THRESH_RESET = 40'd268435456;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ACCESS = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SHRINK = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PLAY   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STAT_W-1:0] ST_LOADED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_LOADFAIL = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd4;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd5;
  localparam logic [STAT_W-1:0] ST_SHRUNK   = 3'd6;

  // Table write request
  typedef struct packed {
    logic               en_data;
    logic               en_flags;
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic [STAMP_W-1:0] stamp;
    logic               valid;
    logic               busy;
    logic               evict;
  } tbl_wr_t;

  // Table read data
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic [STAMP_W-1:0] stamp;
    logic               valid;
    logic               busy;
    logic               evict;
  } tbl_rd_t;

  // Scan results
  typedef struct packed {
    logic               found;
    logic               hit_evict;
    logic [BYTES_W-1:0] hit_bytes;
    logic               free_found;
    logic               pick_found;
    logic               pick_busy;
    logic [BYTES_W-1:0] pick_bytes;
  } scan_res_t;

endpackage

`default_nettype wire

[design/size_bounded_lru_cache.sv]
// Size-bounded LRU cache: sequencer, byte total and result register.
// Access, remove and set playing each take one table scan. Shrink and flush scan
// the table once per evicted or skipped entry, plus once for a last scan that finds
// no eligible entry. One item at a time: a new item is taken only once the last
// result is in the result register; uses sblc_table, sblc_scan.
// Reset (rst_n, synchronous): table empty, total zero, threshold 268435456.
`timescale 1ns / 1ps
`default_nettype none

module size_bounded_lru_cache
  import sblc_pkg::*;
#(
  parameter int unsigned ENTRIES = SBLC_ENTRIES
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // key, load_size, now, playing
  input  wire logic [2:0]   in_tuser,   // action
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // freed_bytes, evicted_count, skipped_count, total_bytes
  output logic [2:0]        out_tuser,  // status
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [39:0]  cfg_data    // size_threshold
);

  localparam int unsigned IW = $clog2(ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHK   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_APPLY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [TOTAL_W-1:0] thresh_r, total_r, total_nxt, limit_r, freed_r;
  logic [ACT_W-1:0]   act_r;
  logic [KEY_W-1:0]   key_r;
  logic [BYTES_W-1:0] load_r;
  logic [STAMP_W-1:0] now_r;
  logic               play_r;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [CNT_W-1:0]   ev_r, sk_r;
  logic               in_xfer;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [TOTAL_W-1:0] out_freed_r, out_total_r;
  logic [CNT_W-1:0]   out_ev_r, out_sk_r;

  tbl_rd_t   rd_data;
  tbl_wr_t   wr;
  logic [IW-1:0] wr_addr, rd_addr, hit_idx, free_idx, pick_idx;
  logic      rd_en, scan_start, scan_done;
  scan_res_t res;

  logic [TOTAL_W:0]   add_sum;
  logic [TOTAL_W-1:0] sub_val;

  sblc_table #(.ENTRIES(ENTRIES)) u_table (
    .clk, .rst_n, .rd_en, .rd_addr, .rd_data, .wr_addr, .wr
  );

  sblc_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk, .rst_n, .start(scan_start), .search_key(key_r), .rd_data,
    .rd_en, .rd_addr, .done(scan_done), .res, .hit_idx, .free_idx, .pick_idx
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) thresh_r <= THRESH_RESET;
    else if (cfg_valid) thresh_r <= cfg_data;
  end

  // Sequencer and table updates
  always_comb begin
    state_nxt  = state_r;
    scan_start = 1'b0;
    wr         = '0;
    wr_addr    = hit_idx;
    total_nxt  = total_r;
    status_nxt = status_r;
    add_sum    = {1'b0, total_r} + (TOTAL_W + 1)'(load_r);
    sub_val    = (act_r == ACT_REMOVE) ? TOTAL_W'(res.hit_bytes)
                                       : TOTAL_W'(res.pick_bytes);
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (in_tuser == ACT_SHRINK || in_tuser == ACT_FLUSH) begin
            state_nxt = S_CHK;
          end else if (in_tuser == ACT_ACCESS || in_tuser == ACT_REMOVE ||
                       in_tuser == ACT_PLAY) begin
            state_nxt  = S_SCAN;
            scan_start = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CHK: begin
        if (total_r >= limit_r) begin
          state_nxt  = S_SCAN;
          scan_start = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        state_nxt = S_DONE;
        priority if (act_r == ACT_ACCESS) begin
          priority if (res.found) begin
            wr.en_data = 1'b1;
            wr.key     = key_r;
            wr.bytes   = res.hit_bytes;
            wr.stamp   = now_r;
            status_nxt = ST_HIT;
          end else if (load_r == '0) begin
            status_nxt = ST_LOADFAIL;
          end else if (res.free_found) begin
            wr_addr     = free_idx;
            wr.en_data  = 1'b1;
            wr.en_flags = 1'b1;
            wr.key      = key_r;
            wr.bytes    = load_r;
            wr.stamp    = now_r;
            wr.valid    = 1'b1;
            wr.evict    = 1'b1;
            total_nxt   = add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];
            status_nxt  = ST_LOADED;
          end else begin
            status_nxt = ST_FULL;
          end
        end else if (act_r == ACT_REMOVE) begin
          if (res.found) begin
            wr.en_flags = 1'b1;
            total_nxt   = (sub_val >= total_r) ? '0 : total_r - sub_val;
            status_nxt  = ST_REMOVED;
          end
        end else if (act_r == ACT_PLAY) begin
          if (res.found) begin
            wr.en_flags = 1'b1;
            wr.valid    = 1'b1;
            wr.busy     = play_r;
            wr.evict    = res.hit_evict;
            status_nxt  = ST_HIT;
          end
        end else begin
          // Shrink or flush: evict or skip the oldest eligible entry
          if (res.pick_found) begin
            state_nxt   = S_CHK;
            wr_addr     = pick_idx;
            wr.en_flags = 1'b1;
            if (res.pick_busy) begin
              wr.valid = 1'b1;
              wr.busy  = 1'b1;
            end else begin
              total_nxt = (sub_val >= total_r) ? '0 : total_r - sub_val;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
    end
  end

  // Latch the item and record its status, freed bytes and shrink counts
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r    <= in_tuser;
      key_r    <= in_tdata[31:0];
      load_r   <= in_tdata[63:32];
      now_r    <= in_tdata[95:64];
      play_r   <= in_tdata[96];
      limit_r  <= (in_tuser == ACT_FLUSH) ? '0 : thresh_r;
      status_r <= (in_tuser == ACT_SHRINK || in_tuser == ACT_FLUSH) ? ST_SHRUNK
                                                                   : ST_ABSENT;
      freed_r  <= '0;
      ev_r     <= '0;
      sk_r     <= '0;
    end else if (state_r == S_APPLY) begin
      status_r <= status_nxt;
      if (act_r == ACT_REMOVE && res.found) begin
        freed_r <= sub_val;
      end else if ((act_r == ACT_SHRINK || act_r == ACT_FLUSH) && res.pick_found) begin
        if (res.pick_busy) begin
          sk_r <= sk_r + 1'b1;
        end else begin
          ev_r    <= ev_r + 1'b1;
          freed_r <= freed_r + sub_val;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_status_r <= status_r;
      out_freed_r  <= freed_r;
      out_ev_r     <= ev_r;
      out_sk_r     <= sk_r;
      out_total_r  <= total_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_total_r, out_sk_r, out_ev_r, out_freed_r};

endmodule

`default_nettype wire

[design/sblc_table.sv]
// Entry table: key, byte size and stamp memories plus per-entry flags.
// Depends on sblc_pkg. One write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sblc_table
  import sblc_pkg::*;
#(
  parameter int unsigned ENTRIES = SBLC_ENTRIES,
  localparam int unsigned IW = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output tbl_rd_t            rd_data,
  input  wire logic [IW-1:0] wr_addr,
  input  tbl_wr_t            wr
);

  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [BYTES_W-1:0] bytes_mem [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r, busy_r, evict_r;
  tbl_rd_t            rd_r;

  // Write payload memories
  always_ff @(posedge clk) begin
    if (wr.en_data) begin
      key_mem[wr_addr]   <= wr.key;
      bytes_mem[wr_addr] <= wr.bytes;
      stamp_mem[wr_addr] <= wr.stamp;
    end
  end

  // Write flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= '0;
      evict_r <= '0;
    end else if (wr.en_flags) begin
      valid_r[wr_addr] <= wr.valid;
      busy_r[wr_addr]  <= wr.busy;
      evict_r[wr_addr] <= wr.evict;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.key   <= key_mem[rd_addr];
      rd_r.bytes <= bytes_mem[rd_addr];
      rd_r.stamp <= stamp_mem[rd_addr];
      rd_r.valid <= valid_r[rd_addr];
      rd_r.busy  <= busy_r[rd_addr];
      rd_r.evict <= evict_r[rd_addr];
    end
  end

  assign rd_data = rd_r;

endmodule

`default_nettype wire

[design/sblc_scan.sv]
// Scan unit: walks the table once, finding key match, first free slot and
// oldest eligible entry. Depends on sblc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sblc_scan
  import sblc_pkg::*;
#(
  parameter int unsigned ENTRIES = SBLC_ENTRIES,
  localparam int unsigned IW = $clog2(ENTRIES)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] search_key,
  input  tbl_rd_t               rd_data,
  output logic                  rd_en,
  output logic [IW-1:0]         rd_addr,
  output logic                  done,
  output scan_res_t             res,
  output logic [IW-1:0]         hit_idx,
  output logic [IW-1:0]         free_idx,
  output logic [IW-1:0]         pick_idx
);

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic               iss_r, cmp_v_r;
  logic [IW-1:0]      cnt_r, cmp_idx_r;
  scan_res_t          res_r;
  logic [IW-1:0]      hit_idx_r, free_idx_r, pick_idx_r;
  logic [STAMP_W-1:0] pick_stamp_r;
  logic               is_match, is_free, is_older;

  // Advance read address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r   <= 1'b0;
      cmp_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      cmp_v_r   <= iss_r;
      cmp_idx_r <= cnt_r;
      if (start) begin
        iss_r <= 1'b1;
        cnt_r <= '0;
      end else if (iss_r) begin
        if (cnt_r == LAST) iss_r <= 1'b0;
        else cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Compare one entry per cycle
  assign is_match = rd_data.valid && (rd_data.key == search_key) && !res_r.found;
  assign is_free  = !rd_data.valid && !res_r.free_found;
  assign is_older = rd_data.valid && rd_data.evict &&
                    (!res_r.pick_found || (rd_data.stamp < pick_stamp_r));

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      res_r.found      <= 1'b0;
      res_r.free_found <= 1'b0;
      res_r.pick_found <= 1'b0;
    end else if (cmp_v_r) begin
      if (is_match) begin
        res_r.found     <= 1'b1;
        res_r.hit_evict <= rd_data.evict;
        res_r.hit_bytes <= rd_data.bytes;
        hit_idx_r       <= cmp_idx_r;
      end
      if (is_free) begin
        res_r.free_found <= 1'b1;
        free_idx_r       <= cmp_idx_r;
      end
      if (is_older) begin
        res_r.pick_found <= 1'b1;
        res_r.pick_busy  <= rd_data.busy;
        res_r.pick_bytes <= rd_data.bytes;
        pick_stamp_r     <= rd_data.stamp;
        pick_idx_r       <= cmp_idx_r;
      end
    end
  end

  assign rd_en    = iss_r;
  assign rd_addr  = cnt_r;
  assign done     = cmp_v_r && (cmp_idx_r == LAST);
  assign res      = res_r;
  assign hit_idx  = hit_idx_r;
  assign free_idx = free_idx_r;
  assign pick_idx = pick_idx_r;

endmodule

`default_nettype wire

[dv/size_bounded_lru_cache_chk.sv]
// Checker for the size-bounded LRU cache: watches the input, result and threshold channels.
// Predicts each result with its own model of the table and compares field by field.
// Depends on sblc_pkg.
`timescale 1ns / 1ps

module size_bounded_lru_cache_chk
  import sblc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic [2:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [39:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam logic [39:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  status;
    logic [39:0] freed;
    logic [4:0]  evicted;
    logic [4:0]  skipped;
    logic [39:0] total;
  } cache_result_t;

  // Shadow copy of the table
  logic        slot_used  [SBLC_ENTRIES];
  logic [31:0] slot_key   [SBLC_ENTRIES];
  logic [31:0] slot_bytes [SBLC_ENTRIES];
  logic [31:0] slot_stamp [SBLC_ENTRIES];
  logic        slot_busy  [SBLC_ENTRIES];
  logic        slot_elig  [SBLC_ENTRIES];
  logic [39:0] shadow_total;
  logic [39:0] shadow_thresh;

  cache_result_t result_queue[$];

  function automatic int lookup(input logic [31:0] k);
    for (int i = 0; i < SBLC_ENTRIES; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void total_sub(input logic [39:0] v);
    shadow_total = (v >= shadow_total) ? 40'd0 : shadow_total - v;
  endfunction

  function automatic void release_slot(input int i);
    total_sub({8'd0, slot_bytes[i]});
    slot_used[i] = 1'b0;
    slot_busy[i] = 1'b0;
    slot_elig[i] = 1'b0;
  endfunction

  // Evict or skip oldest eligible entries until the total drops below the limit or none is left
  function automatic void run_shrink(input logic [39:0] limit, inout cache_result_t r);
    int pick;
    while (shadow_total >= limit) begin
      pick = -1;
      for (int i = 0; i < SBLC_ENTRIES; i++)
        if (slot_used[i] && slot_elig[i] && (pick < 0 || slot_stamp[i] < slot_stamp[pick]))
          pick = i;
      if (pick < 0) break;
      if (slot_busy[pick]) begin
        slot_elig[pick] = 1'b0;
        r.skipped++;
      end else begin
        r.freed += slot_bytes[pick];
        r.evicted++;
        release_slot(pick);
      end
    end
  endfunction

  function automatic cache_result_t predict_cache(input logic [2:0] act,
      input logic [31:0] k, input logic [31:0] load, input logic [31:0] stamp,
      input logic play);
    cache_result_t r;
    int s;
    logic [40:0] sum;
    r = '0;
    r.status = ST_ABSENT;
    case (act)
      ACT_ACCESS: begin
        s = lookup(k);
        if (s >= 0) begin
          slot_stamp[s] = stamp;
          r.status = ST_HIT;
        end else if (load == 0) begin
          r.status = ST_LOADFAIL;
        end else begin
          s = -1;
          for (int i = SBLC_ENTRIES - 1; i >= 0; i--)
            if (!slot_used[i]) s = i;
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_used[s] = 1'b1;
            slot_key[s] = k;
            slot_bytes[s] = load;
            slot_stamp[s] = stamp;
            slot_busy[s] = 1'b0;
            slot_elig[s] = 1'b1;
            sum = shadow_total + load;
            shadow_total = sum[40] ? TOTAL_MAX : sum[39:0];
            r.status = ST_LOADED;
          end
        end
      end
      ACT_SHRINK: begin
        run_shrink(shadow_thresh, r);
        r.status = ST_SHRUNK;
      end
      ACT_FLUSH: begin
        run_shrink(40'd0, r);
        r.status = ST_SHRUNK;
      end
      ACT_REMOVE: begin
        s = lookup(k);
        if (s >= 0) begin
          r.freed = slot_bytes[s];
          release_slot(s);
          r.status = ST_REMOVED;
        end
      end
      ACT_PLAY: begin
        s = lookup(k);
        if (s >= 0) begin
          slot_busy[s] = play;
          r.status = ST_HIT;
        end
      end
      default: ;
    endcase
    r.total = shadow_total;
    return r;
  endfunction

  assign pending = result_queue.size();

  // Predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    cache_result_t want;
    cache_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < SBLC_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_busy[i] = 1'b0;
        slot_elig[i] = 1'b0;
        slot_key[i] = '0;
        slot_bytes[i] = '0;
        slot_stamp[i] = '0;
      end
      shadow_total = '0;
      shadow_thresh = THRESH_RESET;
      result_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) shadow_thresh = cfg_data;
      if (in_tvalid && in_tready)
        result_queue.push_back(predict_cache(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                             in_tdata[95:64], in_tdata[96]));
      if (out_tvalid && out_tready) begin
        got.status  = out_tuser;
        got.freed   = out_tdata[39:0];
        got.evicted = out_tdata[44:40];
        got.skipped = out_tdata[49:45];
        got.total   = out_tdata[89:50];
        if (result_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = result_queue.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.freed !== want.freed) begin
            $error("freed_bytes: expected %0d, got %0d", want.freed, got.freed);
            fail_count++;
          end
          if (got.evicted !== want.evicted) begin
            $error("evicted_count: expected %0d, got %0d", want.evicted, got.evicted);
            fail_count++;
          end
          if (got.skipped !== want.skipped) begin
            $error("skipped_count: expected %0d, got %0d", want.skipped, got.skipped);
            fail_count++;
          end
          if (got.total !== want.total) begin
            $error("total_bytes: expected %0d, got %0d", want.total, got.total);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

[dv/size_bounded_lru_cache_tb.sv]
// Testbench top for the size-bounded LRU cache: clock, reset, stimulus and verdict.
// Depends on sblc_pkg, the block and size_bounded_lru_cache_chk.
`timescale 1ns / 1ps

module size_bounded_lru_cache_tb;
  import sblc_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [39:0]  cfg_data = '0;
  int           fail_count;
  int           pending;
  int           items_sent = 0;
  int           burst_left = 0;
  logic [31:0]  tick = 0;
  logic [31:0]  key_pool [8];

  always #10 clk = ~clk;

  size_bounded_lru_cache dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  size_bounded_lru_cache_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stall pattern: long ready stretches, short and long stalls
  always @(negedge clk) begin
    case (($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 3))
      0: out_tready <= 1'b1;
      1: out_tready <= 1'b0;
      2: out_tready <= ~out_tready;
      default: out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Hold off in bursts: drop valid for a random gap between runs of items
  task automatic sender_gap();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(input logic [2:0] act, input logic [31:0] k,
      input logic [31:0] load, input logic [31:0] stamp, input logic play);
    sender_gap();
    in_tuser  <= act;
    in_tdata  <= {7'd0, play, stamp, load, k};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Drain results, let the block settle, then write the threshold
  task automatic set_threshold(input logic [39:0] value);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3 * SBLC_ENTRIES + 10) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(input logic [39:0] size_scale);
    logic [31:0] k;
    logic [31:0] load;
    logic        play;
    int pick;
    k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
    load = (size_scale == 0) ? $urandom() : $urandom_range(0, 32'hFFFF);
    if ($urandom_range(0, 15) == 0) load = 0;
    tick = ($urandom_range(0, 19) == 0) ? $urandom() : tick + $urandom_range(0, 3);
    play = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 55)      send_item(ACT_ACCESS, k, load, tick, play);
    else if (pick < 70) send_item(ACT_SHRINK, k, load, tick, play);
    else if (pick < 74) send_item(ACT_FLUSH, k, load, tick, play);
    else if (pick < 84) send_item(ACT_REMOVE, k, load, tick, play);
    else if (pick < 97) send_item(ACT_PLAY, k, load, tick, play);
    else                send_item(3'($urandom_range(5, 7)), k, load, tick, play);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every action, table full, skip
    send_item(ACT_SHRINK, 0, 0, 0, 0);
    send_item(ACT_ACCESS, 32'hFFFF_FFFF, 0, 5, 0);
    send_item(ACT_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_item(ACT_ACCESS, 32'hFFFF_FFFF, 7, 3, 0);
    send_item(ACT_PLAY, 32'hFFFF_FFFF, 0, 0, 1);
    for (int i = 0; i < SBLC_ENTRIES; i++)
      send_item(ACT_ACCESS, i, 32'hFFFF_FFFF, 10 + i, 0);
    send_item(ACT_REMOVE, 32'h1234_5678, 0, 0, 0);
    send_item(ACT_SHRINK, 0, 0, 0, 0);
    send_item(ACT_REMOVE, 3, 0, 0, 0);
    send_item(ACT_PLAY, 3, 0, 0, 0);
    send_item(3'd7, 1, 1, 1, 1);
    send_item(ACT_FLUSH, 0, 0, 0, 0);
    send_item(ACT_FLUSH, 0, 0, 0, 0);

    // Random phases over several thresholds, extremes included
    set_threshold(40'd0);
    repeat (150) random_item(1);
    set_threshold(40'hFF_FFFF_FFFF);
    repeat (120) random_item(0);
    set_threshold(40'($urandom_range(1, 32'h0004_0000)));
    repeat (180) random_item(1);
    set_threshold({8'($urandom_range(0, 255)), $urandom()});
    repeat (150) random_item(0);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SBLC_ENTRIES * 60) @(negedge clk);
    $display("Sent %0d items: every action, full table, playing skips, four thresholds.",
             items_sent);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
